[rtl/sfd_pkg.sv]
// shared types and constants for the serial frame deframer with checksum
// no dependencies; imported by sfd_frame_fsm and serial_frame_deframer_checksum_unit
`default_nettype none

package sfd_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned SUM_WIDTH       = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_SIGNATURE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_SIGNATURE = 2'd1;

   localparam logic [BYTE_WIDTH-1:0] FIRST_SIGNATURE_RESET  = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] SECOND_SIGNATURE_RESET = 8'hAA;

   localparam logic [SUM_WIDTH-1:0] CHECKSUM_INVERT = 16'hFFFF;

   localparam logic [BYTE_WIDTH-1:0] CURSOR_SOURCE   = 8'd0;
   localparam logic [BYTE_WIDTH-1:0] CURSOR_COMMAND  = 8'd1;
   localparam logic [BYTE_WIDTH-1:0] CURSOR_ARGUMENT = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] HEADER_BYTES    = 8'd3;
   localparam logic [BYTE_WIDTH-1:0] MIN_LENGTH      = 8'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CHECKSUM  = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT_FIRST  = 3'd0,
      PH_HUNT_SECOND = 3'd1,
      PH_LENGTH      = 3'd2,
      PH_BODY        = 3'd3,
      PH_CHECK_LOW   = 3'd4,
      PH_CHECK_HIGH  = 3'd5
   } phase_type;

   typedef struct packed {
      logic                  kind;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic [BYTE_WIDTH-1:0] payload_index;
      logic [BYTE_WIDTH-1:0] frame_source;
      logic [BYTE_WIDTH-1:0] frame_command;
      logic [BYTE_WIDTH-1:0] frame_argument;
      logic [BYTE_WIDTH-1:0] payload_count;
      status_type            status;
      logic                  frame_last;
   } result_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] first_signature;
      logic [BYTE_WIDTH-1:0] second_signature;
   } signature_type;

endpackage

`default_nettype wire

[rtl/serial_frame_deframer_checksum_unit.sv]
// top level of the serial frame deframer: signature registers, frame fsm, result register
// depends on sfd_pkg and sfd_frame_fsm
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_rx_byte
//  rsp      out        rsp_valid/rsp_ready  kind, data, index, header, count, status, last
//  csr      in         csr_write_enable     csr_index, csr_write_data
//
// one word is accepted per cycle while no stalled result holds intake back; the result, if any, shows in the next cycle
// the output register lets a new word in while its result is taken the same cycle
// a stalled result holds intake back only while it is not being taken
// synchronous reset clears the phase, the cursor and the output valid
// signatures reset to 0x55 and 0xaa
`default_nettype none

module serial_frame_deframer_checksum_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sfd_pkg::BYTE_WIDTH-1:0]      req_rx_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_kind,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_data_byte,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_payload_index,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_frame_source,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_frame_command,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_frame_argument,
   output logic [sfd_pkg::BYTE_WIDTH-1:0]           rsp_payload_count,
   output logic [1:0]                             rsp_status,
   output logic                                   rsp_frame_last,
   input  wire logic                              csr_write_enable,
   input  wire logic [sfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sfd_pkg::BYTE_WIDTH-1:0]      csr_write_data
);
   import sfd_pkg::*;

   signature_type signatures_ff;
   result_type    result;
   result_type    rsp_data_ff;
   logic          rsp_valid_ff;
   logic          produced;
   logic          step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         signatures_ff.first_signature  <= FIRST_SIGNATURE_RESET;
         signatures_ff.second_signature <= SECOND_SIGNATURE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_SIGNATURE:  signatures_ff.first_signature  <= csr_write_data;
            CSR_SECOND_SIGNATURE: signatures_ff.second_signature <= csr_write_data;
            default: ;
         endcase
      end
   end

   sfd_frame_fsm u_frame_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (req_rx_byte),
      .signatures (signatures_ff),
      .result     (result),
      .produced   (produced)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && produced) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && produced) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_data_ff.kind;
   assign rsp_data_byte      = rsp_data_ff.data_byte;
   assign rsp_payload_index  = rsp_data_ff.payload_index;
   assign rsp_frame_source   = rsp_data_ff.frame_source;
   assign rsp_frame_command  = rsp_data_ff.frame_command;
   assign rsp_frame_argument = rsp_data_ff.frame_argument;
   assign rsp_payload_count  = rsp_data_ff.payload_count;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_frame_last     = rsp_data_ff.frame_last;

`ifndef SYNTHESIS
   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_last == rsp_kind))
      else $error("frame_last and kind disagree");
   a_frame_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> (rsp_data_byte == '0 && rsp_payload_index == '0))
      else $error("frame result carries payload fields");
   a_payload_zero_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_last) |-> (rsp_status == STATUS_OK && rsp_payload_count == '0))
      else $error("payload result carries frame fields");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("illegal status code");
   a_new_result_on_step: assert property (@(posedge clock) disable iff (reset)
      (step && produced) |=> rsp_valid)
      else $error("produced result was lost");
`endif

endmodule

`default_nettype wire

[rtl/sfd_frame_fsm.sv]
// frame state machine: preamble hunt, length, body, checksum, result per payload byte and per frame
// depends on sfd_pkg
`default_nettype none

module sfd_frame_fsm (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [sfd_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  wire sfd_pkg::signature_type       signatures,
   output sfd_pkg::result_type               result,
   output logic                              produced
);
   import sfd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0] frame_length_ff, frame_length_in;
   logic [BYTE_WIDTH-1:0] body_cursor_ff, body_cursor_in;
   logic [SUM_WIDTH-1:0]  running_sum_ff, running_sum_in;
   logic [BYTE_WIDTH-1:0] held_source_ff, held_source_in;
   logic [BYTE_WIDTH-1:0] held_command_ff, held_command_in;
   logic [BYTE_WIDTH-1:0] held_argument_ff, held_argument_in;
   logic [BYTE_WIDTH-1:0] checksum_low_ff, checksum_low_in;

   logic [SUM_WIDTH-1:0]  sum_next;
   logic [SUM_WIDTH-1:0]  checksum_got;
   logic [SUM_WIDTH-1:0]  checksum_want;
   logic                  short_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT_FIRST;
         body_cursor_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         body_cursor_ff <= body_cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         frame_length_ff  <= frame_length_in;
         running_sum_ff   <= running_sum_in;
         held_source_ff   <= held_source_in;
         held_command_ff  <= held_command_in;
         held_argument_ff <= held_argument_in;
         checksum_low_ff  <= checksum_low_in;
      end
   end

   assign sum_next      = running_sum_ff + {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, rx_byte};
   assign checksum_got  = {rx_byte, checksum_low_ff};
   assign checksum_want = running_sum_ff ^ CHECKSUM_INVERT;
   assign short_length  = frame_length_ff < MIN_LENGTH;

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      body_cursor_in   = body_cursor_ff;
      running_sum_in   = running_sum_ff;
      held_source_in   = held_source_ff;
      held_command_in  = held_command_ff;
      held_argument_in = held_argument_ff;
      checksum_low_in  = checksum_low_ff;
      result           = '0;
      produced         = 1'b0;
      unique case (phase_ff)
         PH_HUNT_SECOND: begin
            phase_in = (rx_byte == signatures.second_signature) ? PH_LENGTH : PH_HUNT_FIRST;
         end
         PH_LENGTH: begin
            frame_length_in  = rx_byte;
            running_sum_in   = {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, rx_byte};
            body_cursor_in   = '0;
            held_source_in   = '0;
            held_command_in  = '0;
            held_argument_in = '0;
            phase_in         = PH_BODY;
         end
         PH_BODY: begin
            running_sum_in = sum_next;
            if (body_cursor_ff == CURSOR_SOURCE) begin
               held_source_in = rx_byte;
            end else if (body_cursor_ff == CURSOR_COMMAND) begin
               held_command_in = rx_byte;
            end else if (body_cursor_ff == CURSOR_ARGUMENT) begin
               held_argument_in = rx_byte;
            end else begin
               result.kind          = KIND_PAYLOAD;
               result.data_byte     = rx_byte;
               result.payload_index = body_cursor_ff - HEADER_BYTES;
               produced             = 1'b1;
            end
            if (body_cursor_ff == frame_length_ff) begin
               phase_in = PH_CHECK_LOW;
            end
            body_cursor_in = body_cursor_ff + 8'd1;
         end
         PH_CHECK_LOW: begin
            checksum_low_in = rx_byte;
            phase_in        = PH_CHECK_HIGH;
         end
         PH_CHECK_HIGH: begin
            result.kind           = KIND_FRAME;
            result.frame_source   = held_source_ff;
            result.frame_command  = held_command_ff;
            result.frame_argument = held_argument_ff;
            result.payload_count  = short_length ? '0 : frame_length_ff - MIN_LENGTH;
            if (short_length) begin
               result.status = STATUS_MALFORMED;
            end else if (checksum_got != checksum_want) begin
               result.status = STATUS_CHECKSUM;
            end else begin
               result.status = STATUS_OK;
            end
            result.frame_last = 1'b1;
            produced          = 1'b1;
            phase_in          = PH_HUNT_FIRST;
         end
         default: begin
            phase_in = (rx_byte == signatures.first_signature) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
         end
      endcase
   end

endmodule

`default_nettype wire

[verif/serial_frame_deframer_checksum_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for serial_frame_deframer_checksum_unit: random bursts of
// framed, noisy and broken byte streams under several signature settings
// depends on sfd_pkg and the deframer rtl

module serial_frame_deframer_checksum_unit_test;
   import sfd_pkg::*;

   localparam int unsigned PHASES          = 7;
   localparam int unsigned WORDS_PER_PHASE = 272;
   localparam int unsigned LONG_HOLD       = 250;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_kind;
   logic [BYTE_WIDTH-1:0]      rsp_data_byte;
   logic [BYTE_WIDTH-1:0]      rsp_payload_index;
   logic [BYTE_WIDTH-1:0]      rsp_frame_source;
   logic [BYTE_WIDTH-1:0]      rsp_frame_command;
   logic [BYTE_WIDTH-1:0]      rsp_frame_argument;
   logic [BYTE_WIDTH-1:0]      rsp_payload_count;
   logic [1:0]                 rsp_status;
   logic                       rsp_frame_last;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [BYTE_WIDTH-1:0]      csr_write_data = '0;

   serial_frame_deframer_checksum_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_frame_source   (rsp_frame_source),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_frame_argument (rsp_frame_argument),
      .rsp_payload_count  (rsp_payload_count),
      .rsp_status         (rsp_status),
      .rsp_frame_last     (rsp_frame_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // deframer shadow state
   logic [BYTE_WIDTH-1:0] sig_first    = FIRST_SIGNATURE_RESET;
   logic [BYTE_WIDTH-1:0] sig_second   = SECOND_SIGNATURE_RESET;
   phase_type             frame_phase  = PH_HUNT_FIRST;
   logic [BYTE_WIDTH-1:0] declared_len = '0;
   logic [BYTE_WIDTH-1:0] body_pos     = '0;
   logic [SUM_WIDTH-1:0]  byte_sum     = '0;
   logic [BYTE_WIDTH-1:0] src_byte     = '0;
   logic [BYTE_WIDTH-1:0] cmd_byte     = '0;
   logic [BYTE_WIDTH-1:0] arg_byte     = '0;
   logic [BYTE_WIDTH-1:0] sum_low_byte = '0;

   logic [BYTE_WIDTH-1:0] pending_bytes[$];
   result_type            due_results[$];
   result_type            want;

   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned results_checked = 0;
   int unsigned payload_seen = 0;
   int unsigned frame_status_seen[3] = '{0, 0, 0};
   int unsigned register_writes = 0;

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   int unsigned ready_mode = 0;
   int unsigned mode_left = 0;
   int unsigned pattern_step = 0;

   function automatic void deframe_byte(input logic [BYTE_WIDTH-1:0] b);
      result_type r;
      r = '0;
      case (frame_phase)
         PH_HUNT_SECOND: frame_phase = (b == sig_second) ? PH_LENGTH : PH_HUNT_FIRST;
         PH_LENGTH: begin
            declared_len = b;
            byte_sum = {8'h00, b};
            body_pos = '0;
            src_byte = '0;
            cmd_byte = '0;
            arg_byte = '0;
            frame_phase = PH_BODY;
         end
         PH_BODY: begin
            byte_sum = byte_sum + b;
            if (body_pos == CURSOR_SOURCE) begin
               src_byte = b;
            end else if (body_pos == CURSOR_COMMAND) begin
               cmd_byte = b;
            end else if (body_pos == CURSOR_ARGUMENT) begin
               arg_byte = b;
            end else begin
               r.kind = KIND_PAYLOAD;
               r.data_byte = b;
               r.payload_index = body_pos - HEADER_BYTES;
               r.status = STATUS_OK;
               due_results.push_back(r);
            end
            if (body_pos == declared_len) frame_phase = PH_CHECK_LOW;
            body_pos = body_pos + 1'b1;
         end
         PH_CHECK_LOW: begin
            sum_low_byte = b;
            frame_phase = PH_CHECK_HIGH;
         end
         PH_CHECK_HIGH: begin
            r.kind = KIND_FRAME;
            r.frame_source = src_byte;
            r.frame_command = cmd_byte;
            r.frame_argument = arg_byte;
            r.frame_last = 1'b1;
            if (declared_len < MIN_LENGTH) begin
               r.payload_count = '0;
               r.status = STATUS_MALFORMED;
            end else begin
               r.payload_count = declared_len - MIN_LENGTH;
               r.status = ({b, sum_low_byte} != (byte_sum ^ CHECKSUM_INVERT)) ?
                          STATUS_CHECKSUM : STATUS_OK;
            end
            due_results.push_back(r);
            frame_phase = PH_HUNT_FIRST;
         end
         default: frame_phase = (b == sig_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] expected_value,
                                       input logic [7:0] actual_value);
      if (actual_value !== expected_value) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  expected_value, actual_value);
         mismatches++;
      end
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] random_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void offer(input logic [BYTE_WIDTH-1:0] value);
      pending_bytes.push_back(value);
      bytes_queued++;
   endfunction

   // preamble, length, body and checksum; optionally corrupted or cut short
   task automatic queue_frame(input logic [BYTE_WIDTH-1:0] length,
                              input logic [BYTE_WIDTH-1:0] body[$],
                              input bit corrupt, input bit truncate);
      logic [BYTE_WIDTH-1:0] frame_q[$];
      logic [SUM_WIDTH-1:0]  sum;
      logic [SUM_WIDTH-1:0]  check;
      int unsigned           keep;
      sum = {8'h00, length};
      frame_q = '{sig_first, sig_second, length};
      foreach (body[i]) begin
         frame_q.push_back(body[i]);
         sum = sum + body[i];
      end
      check = sum ^ CHECKSUM_INVERT;
      if (corrupt) check = check ^ (16'h0001 << $urandom_range(0, 15));
      frame_q.push_back(check[7:0]);
      frame_q.push_back(check[15:8]);
      keep = truncate ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
      for (int i = 0; i < keep; i++) offer(frame_q[i]);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [BYTE_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_FIRST_SIGNATURE) sig_first = value;
      else if (index == CSR_SECOND_SIGNATURE) sig_second = value;
      register_writes++;
   endtask

   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
                               $urandom_range(1, 16);
                  gap_left = $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each word and stalls in changing modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual kind %0h data %0h",
                        $time, rsp_kind, rsp_data_byte);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("payload_index", want.payload_index, rsp_payload_index);
               check_field("frame_source", want.frame_source, rsp_frame_source);
               check_field("frame_command", want.frame_command, rsp_frame_command);
               check_field("frame_argument", want.frame_argument, rsp_frame_argument);
               check_field("payload_count", want.payload_count, rsp_payload_count);
               check_field("status", want.status, rsp_status);
               check_field("frame_last", want.frame_last, rsp_frame_last);
               if (want.kind == KIND_PAYLOAD) payload_seen++;
               else frame_status_seen[int'(want.status)]++;
               results_checked++;
            end
         end
         // one long hold-off while the sender keeps offering
         if (!long_hold_done && results_checked >= 300 && req_valid &&
             due_results.size() != 0) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         pattern_step++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (mode_left == 0) begin
            mode_left = $urandom_range(20, 120);
            ready_mode = $urandom_range(0, 3);
            rsp_ready <= 1'b1;
         end else begin
            mode_left--;
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) != 0);
               default: rsp_ready <= ((pattern_step % 5) < 2);
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [BYTE_WIDTH-1:0] body[$];
      logic [BYTE_WIDTH-1:0] length;
      logic [BYTE_WIDTH-1:0] first_pick;
      logic [BYTE_WIDTH-1:0] second_pick;
      int unsigned           phase_start;
      int unsigned           pick;
      int unsigned           sel;
      int unsigned           big_frames;
      big_frames = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wrong second preamble byte is consumed, not retried as a first byte
      offer(FIRST_SIGNATURE_RESET);
      offer(FIRST_SIGNATURE_RESET);
      offer(SECOND_SIGNATURE_RESET);
      body = '{8'h00, 8'hFF, 8'h80, 8'hFF};
      queue_frame(8'd3, body, 1'b0, 1'b0);
      // short length wins over a bad checksum
      body = '{8'h5A};
      queue_frame(8'd0, body, 1'b1, 1'b0);
      body = '{8'h01, 8'h02, 8'h03};
      queue_frame(8'd2, body, 1'b1, 1'b0);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin first_pick = 8'h00; second_pick = 8'hFF; end
            1: begin first_pick = 8'hFF; second_pick = 8'h00; end
            2: begin first_pick = 8'h7E; second_pick = 8'h7E; end
            3: begin first_pick = FIRST_SIGNATURE_RESET; second_pick = SECOND_SIGNATURE_RESET; end
            default: begin first_pick = 8'($urandom); second_pick = 8'($urandom); end
         endcase
         write_register(CSR_FIRST_SIGNATURE, first_pick);
         write_register(CSR_SECOND_SIGNATURE, second_pick);
         if (p == 2) begin
            write_register(CSR_SPARE_LOW, 8'($urandom));
            write_register(CSR_SPARE_HIGH, 8'($urandom));
         end
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 75 || pick >= 93) begin
               sel = $urandom_range(0, 49);
               if ((sel == 0 || (p == 4 && big_frames == 0)) && big_frames < 2) begin
                  length = (big_frames == 0) ? 8'hFF : 8'($urandom_range(250, 254));
                  big_frames++;
               end else if (sel < 5) begin
                  length = 8'($urandom_range(0, 1));
               end else begin
                  length = 8'($urandom_range(2, 16));
               end
               body.delete();
               for (int i = 0; i <= int'(length); i++) body.push_back(random_byte());
               queue_frame(length, body, $urandom_range(0, 5) == 0, pick >= 93);
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 6)) offer(random_byte());
            end else begin
               offer(sig_first);
               offer(sig_second ^ 8'($urandom_range(1, 255)));
            end
         end
         // leave a frame open so the next signature write lands mid-frame
         if (p % 2 == 1) begin
            length = 8'($urandom_range(4, 10));
            body.delete();
            for (int i = 0; i <= int'(length); i++) body.push_back(random_byte());
            queue_frame(length, body, 1'b0, 1'b1);
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d expected words never arrived, actual none", $time,
                  due_results.size());
         mismatches++;
      end
      $display("covered %0d input words over %0d signature settings, %0d register writes",
               bytes_accepted, PHASES + 1, register_writes);
      $display("checked %0d payload words and frames ok %0d, bad checksum %0d, short %0d",
               payload_seen, frame_status_seen[0], frame_status_seen[1], frame_status_seen[2]);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
